// ----- sv/kmc_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, codes and controller/datapath interface types of the k-means engine.
package kmc_pkg;

  localparam int MAX_POINTS   = 1024;
  localparam int MAX_DIMS     = 8;
  localparam int MAX_CLUSTERS = 16;

  localparam int PT_W  = $clog2(MAX_POINTS);
  localparam int DIM_W = $clog2(MAX_DIMS);
  localparam int CL_W  = $clog2(MAX_CLUSTERS);

  localparam int PT_AW  = PT_W + DIM_W;
  localparam int CEN_AW = CL_W + DIM_W;

  localparam int NP_W    = 11;
  localparam int ND_W    = 4;
  localparam int NK_W    = 5;
  localparam int ITER_W  = 16;
  localparam int TOL_W   = 16;
  localparam int COORD_W = 16;
  localparam int OP_W    = 3;

  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int SUM_W  = COORD_W + CNT_W;
  localparam int DIFF_W = COORD_W + 1;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int DIST_W = SQ_W + DIM_W;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;

  localparam logic [OP_W-1:0] OP_LOAD_PT  = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD_CEN = 3'd1;
  localparam logic [OP_W-1:0] OP_RUN      = 3'd2;
  localparam logic [OP_W-1:0] OP_READ_ASG = 3'd3;
  localparam logic [OP_W-1:0] OP_READ_CEN = 3'd4;

  localparam logic [CFG_AW-1:0] REG_NUM_POINTS   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_NUM_DIMS     = 3'd1;
  localparam logic [CFG_AW-1:0] REG_NUM_CLUSTERS = 3'd2;
  localparam logic [CFG_AW-1:0] REG_MAX_ITER     = 3'd3;
  localparam logic [CFG_AW-1:0] REG_TOLERANCE    = 3'd4;

  typedef enum logic [1:0] {
    OUT_ZERO,
    OUT_ASG,
    OUT_CEN
  } out_src_t;

  typedef struct packed {
    logic [PT_W-1:0]           pidx;
    logic [CL_W-1:0]           cidx;
    logic [DIM_W-1:0]          didx;
    logic signed [COORD_W-1:0] coord;
    logic [TOL_W-1:0]          tol;
    logic                      load_pt;
    logic                      load_cen;
    logic                      sum_sel_best;
    logic                      dist_clr;
    logic                      dist_mul;
    logic                      dist_acc;
    logic                      best_upd;
    logic                      asg_we;
    logic                      cnt_clr;
    logic                      sum_we;
    logic                      cnt_inc;
    logic                      div_start;
    logic                      cen_upd;
    logic                      moved_clr;
    logic                      out_ld;
    out_src_t                  out_src;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic moved;
    logic div_done;
  } status_t;

endpackage

// ----- sv/kmc_if.sv -----
`timescale 1ns / 1ps
// Handshake channel interfaces for requests, responses and register writes.
interface kmc_in_if;
  logic                               valid;
  logic                               ready;
  logic [kmc_pkg::OP_W-1:0]           opcode;
  logic [kmc_pkg::PT_W-1:0]           point_index;
  logic [kmc_pkg::CL_W-1:0]           cluster_index;
  logic [kmc_pkg::DIM_W-1:0]          dim_index;
  logic signed [kmc_pkg::COORD_W-1:0] coord_value;

  modport source (output valid, opcode, point_index, cluster_index, dim_index, coord_value,
                  input ready);
  modport sink (input valid, opcode, point_index, cluster_index, dim_index, coord_value,
                output ready);
endinterface

interface kmc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [kmc_pkg::COORD_W-1:0] read_value;
  logic [kmc_pkg::ITER_W-1:0]         iterations_done;
  logic                               converged;

  modport source (output valid, read_value, iterations_done, converged, input ready);
  modport sink (input valid, read_value, iterations_done, converged, output ready);
endinterface

interface kmc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [kmc_pkg::CFG_AW-1:0]  addr;
  logic [kmc_pkg::CFG_DW-1:0]  data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

// ----- sv/kmc_ram.sv -----
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
module kmc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- sv/kmc_divider.sv -----
`timescale 1ns / 1ps
// Restoring divider: signed cluster sum by unsigned member count, truncated toward zero.
module kmc_divider (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [kmc_pkg::SUM_W-1:0]   dividend,
  input  logic [kmc_pkg::CNT_W-1:0]          divisor,
  output logic                               done,
  output logic signed [kmc_pkg::COORD_W-1:0] quotient
);

  localparam int STEP_W = $clog2(kmc_pkg::SUM_W + 1);

  logic [kmc_pkg::CNT_W:0]   rem;
  logic [kmc_pkg::SUM_W-1:0] quo;
  logic [kmc_pkg::CNT_W-1:0] dvs;
  logic [STEP_W-1:0]         steps;
  logic                      busy;
  logic                      neg;
  logic [kmc_pkg::CNT_W:0]   trial;
  logic                      fits;
  logic [kmc_pkg::SUM_W-1:0] signed_quo;

  assign trial      = {rem[kmc_pkg::CNT_W-1:0], quo[kmc_pkg::SUM_W-1]};
  assign fits       = trial >= {1'b0, dvs};
  assign signed_quo = neg ? (~quo + 1'b1) : quo;
  assign quotient   = signed_quo[kmc_pkg::COORD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        rem   <= '0;
        neg   <= dividend[kmc_pkg::SUM_W-1];
        quo   <= dividend[kmc_pkg::SUM_W-1] ? (~dividend + 1'b1) : dividend;
        dvs   <= divisor;
        steps <= STEP_W'(kmc_pkg::SUM_W);
      end else if (busy) begin
        rem   <= fits ? (trial - {1'b0, dvs}) : trial;
        quo   <= {quo[kmc_pkg::SUM_W-2:0], fits};
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- sv/kmc_datapath.sv -----
`timescale 1ns / 1ps
// Datapath: coordinate and result memories, distance unit, cluster sums and mean update.
module kmc_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  kmc_pkg::cmd_t                      cmd,
  output kmc_pkg::status_t                   status,
  output logic signed [kmc_pkg::COORD_W-1:0] read_value
);

  logic signed [kmc_pkg::COORD_W-1:0] pt_q;
  logic signed [kmc_pkg::COORD_W-1:0] cen_q;
  logic [kmc_pkg::CL_W-1:0]           asg_q;
  logic signed [kmc_pkg::SUM_W-1:0]   sum_q;
  logic [kmc_pkg::CL_W-1:0]           best;
  logic [kmc_pkg::DIST_W-1:0]         best_dist;
  logic [kmc_pkg::DIST_W-1:0]         acc_dist;
  logic [kmc_pkg::SQ_W-1:0]           sq;
  logic [kmc_pkg::CNT_W-1:0]          counts [kmc_pkg::MAX_CLUSTERS];
  logic                               moved;

  logic [kmc_pkg::CL_W-1:0]           cnt_sel;
  logic [kmc_pkg::CNT_W-1:0]          cnt_rd;
  logic signed [kmc_pkg::DIFF_W-1:0]  diff;
  logic signed [kmc_pkg::SQ_W-1:0]    prod;
  logic signed [kmc_pkg::SUM_W-1:0]   sum_base;
  logic signed [kmc_pkg::SUM_W-1:0]   sum_new;
  logic signed [kmc_pkg::COORD_W-1:0] nv;
  logic                               div_done;
  logic signed [kmc_pkg::DIFF_W-1:0]  delta;
  logic [kmc_pkg::DIFF_W-1:0]         abs_delta;
  logic signed [kmc_pkg::COORD_W-1:0] cen_wdata;
  logic                               cen_we;
  logic [kmc_pkg::CEN_AW-1:0]         sum_addr;

  assign cnt_sel   = cmd.sum_sel_best ? best : cmd.cidx;
  assign cnt_rd    = counts[cnt_sel];
  assign diff      = {pt_q[kmc_pkg::COORD_W-1], pt_q} - {cen_q[kmc_pkg::COORD_W-1], cen_q};
  assign prod      = diff * diff;
  assign sum_base  = (cnt_rd == '0) ? '0 : sum_q;
  assign sum_new   = sum_base +
                     {{(kmc_pkg::SUM_W-kmc_pkg::COORD_W){pt_q[kmc_pkg::COORD_W-1]}}, pt_q};
  assign delta     = {nv[kmc_pkg::COORD_W-1], nv} - {cen_q[kmc_pkg::COORD_W-1], cen_q};
  assign abs_delta = delta[kmc_pkg::DIFF_W-1] ? (~delta + 1'b1) : delta;
  assign cen_we    = cmd.load_cen | cmd.cen_upd;
  assign cen_wdata = cmd.load_cen ? cmd.coord : nv;
  assign sum_addr  = {cnt_sel, cmd.didx};

  assign status.count_zero = (cnt_rd == '0);
  assign status.moved      = moved;
  assign status.div_done   = div_done;

  kmc_ram #(.WIDTH(kmc_pkg::COORD_W), .DEPTH(kmc_pkg::MAX_POINTS * kmc_pkg::MAX_DIMS)) u_pt_ram (
    .clk   (clk),
    .we    (cmd.load_pt),
    .addr  ({cmd.pidx, cmd.didx}),
    .wdata (cmd.coord),
    .rdata (pt_q)
  );

  kmc_ram #(.WIDTH(kmc_pkg::COORD_W), .DEPTH(kmc_pkg::MAX_CLUSTERS * kmc_pkg::MAX_DIMS))
    u_cen_ram (
    .clk   (clk),
    .we    (cen_we),
    .addr  ({cmd.cidx, cmd.didx}),
    .wdata (cen_wdata),
    .rdata (cen_q)
  );

  kmc_ram #(.WIDTH(kmc_pkg::CL_W), .DEPTH(kmc_pkg::MAX_POINTS)) u_asg_ram (
    .clk   (clk),
    .we    (cmd.asg_we),
    .addr  (cmd.pidx),
    .wdata (best),
    .rdata (asg_q)
  );

  kmc_ram #(.WIDTH(kmc_pkg::SUM_W), .DEPTH(kmc_pkg::MAX_CLUSTERS * kmc_pkg::MAX_DIMS))
    u_sum_ram (
    .clk   (clk),
    .we    (cmd.sum_we),
    .addr  (sum_addr),
    .wdata (sum_new),
    .rdata (sum_q)
  );

  kmc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sum_q),
    .divisor  (cnt_rd),
    .done     (div_done),
    .quotient (nv)
  );

  always_ff @(posedge clk) begin
    if (cmd.dist_mul) begin
      sq <= kmc_pkg::SQ_W'(prod);
    end
    if (cmd.dist_clr) begin
      acc_dist <= '0;
    end else if (cmd.dist_acc) begin
      acc_dist <= acc_dist + kmc_pkg::DIST_W'(sq);
    end
    if (cmd.best_upd && (cmd.cidx == '0 || acc_dist < best_dist)) begin
      best      <= cmd.cidx;
      best_dist <= acc_dist;
    end
    if (cmd.cnt_clr) begin
      for (int k = 0; k < kmc_pkg::MAX_CLUSTERS; k++) begin
        counts[k] <= '0;
      end
    end else if (cmd.cnt_inc) begin
      counts[best] <= counts[best] + 1'b1;
    end
    if (cmd.out_ld) begin
      case (cmd.out_src)
        kmc_pkg::OUT_ASG: read_value <= {{(kmc_pkg::COORD_W-kmc_pkg::CL_W){1'b0}}, asg_q};
        kmc_pkg::OUT_CEN: read_value <= cen_q;
        default:          read_value <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      moved <= 1'b0;
    end else if (cmd.moved_clr) begin
      moved <= 1'b0;
    end else if (cmd.cen_upd && abs_delta > {1'b0, cmd.tol}) begin
      moved <= 1'b1;
    end
  end

endmodule

// ----- sv/kmc_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: handshakes, configuration registers and the iteration sequencer.
module kmc_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  kmc_in_if.sink                     req,
  kmc_cfg_if.sink                    cfg,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [kmc_pkg::ITER_W-1:0] iterations_done,
  output logic                       converged,
  input  kmc_pkg::status_t           status,
  output kmc_pkg::cmd_t              cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_RD_WAIT, S_IT_START, S_PT_HEAD, S_CL_HEAD, S_D_HEAD, S_D_MUL, S_D_ACC,
    S_BEST, S_ASG, S_AC_HEAD, S_AC_WR, S_CNT, S_UPD_HEAD, S_UD_HEAD, S_UD_DIV,
    S_UD_WAIT, S_IT_END
  } state_t;

  state_t                      state;
  logic [kmc_pkg::NP_W-1:0]    num_points;
  logic [kmc_pkg::ND_W-1:0]    num_dims;
  logic [kmc_pkg::NK_W-1:0]    num_clusters;
  logic [kmc_pkg::ITER_W-1:0]  max_iter;
  logic [kmc_pkg::TOL_W-1:0]   tolerance;
  logic [kmc_pkg::NP_W-1:0]    i;
  logic [kmc_pkg::NK_W-1:0]    c;
  logic [kmc_pkg::ND_W-1:0]    d;
  logic [kmc_pkg::ITER_W-1:0]  iters;
  logic                        rd_cen;

  logic [kmc_pkg::NP_W-1:0]    np;
  logic [kmc_pkg::ND_W-1:0]    nd;
  logic [kmc_pkg::NK_W-1:0]    nk;
  logic                        accept;
  logic                        finish;

  assign np = (num_points > kmc_pkg::NP_W'(kmc_pkg::MAX_POINTS)) ?
              kmc_pkg::NP_W'(kmc_pkg::MAX_POINTS) : num_points;
  assign nd = (num_dims > kmc_pkg::ND_W'(kmc_pkg::MAX_DIMS)) ?
              kmc_pkg::ND_W'(kmc_pkg::MAX_DIMS) : num_dims;
  assign nk = (num_clusters > kmc_pkg::NK_W'(kmc_pkg::MAX_CLUSTERS)) ?
              kmc_pkg::NK_W'(kmc_pkg::MAX_CLUSTERS) : num_clusters;

  assign req.ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept    = req.valid && req.ready;
  assign cfg.ready = 1'b1;
  assign finish    = (state == S_IT_END) && (!status.moved || iters == max_iter);

  always_comb begin
    cmd              = '0;
    cmd.coord        = req.coord_value;
    cmd.tol          = tolerance;
    cmd.out_src      = kmc_pkg::OUT_ZERO;
    cmd.pidx         = i[kmc_pkg::PT_W-1:0];
    cmd.cidx         = c[kmc_pkg::CL_W-1:0];
    cmd.didx         = d[kmc_pkg::DIM_W-1:0];
    cmd.sum_sel_best = (state == S_AC_HEAD) || (state == S_AC_WR) || (state == S_CNT);
    case (state)
      S_IDLE: begin
        cmd.pidx = req.point_index;
        cmd.cidx = req.cluster_index;
        cmd.didx = req.dim_index;
        if (accept) begin
          cmd.load_pt  = (req.opcode == kmc_pkg::OP_LOAD_PT);
          cmd.load_cen = (req.opcode == kmc_pkg::OP_LOAD_CEN);
          cmd.out_ld   = (req.opcode != kmc_pkg::OP_READ_ASG) &&
                         (req.opcode != kmc_pkg::OP_READ_CEN) &&
                         ((req.opcode != kmc_pkg::OP_RUN) || (max_iter == '0));
        end
      end
      S_RD_WAIT: begin
        cmd.out_ld  = 1'b1;
        cmd.out_src = rd_cen ? kmc_pkg::OUT_CEN : kmc_pkg::OUT_ASG;
      end
      S_IT_START: begin
        cmd.moved_clr = 1'b1;
        cmd.cnt_clr   = 1'b1;
      end
      S_CL_HEAD: cmd.dist_clr = (c < nk);
      S_D_MUL:   cmd.dist_mul = 1'b1;
      S_D_ACC:   cmd.dist_acc = 1'b1;
      S_BEST:    cmd.best_upd = 1'b1;
      S_ASG:     cmd.asg_we   = 1'b1;
      S_AC_WR:   cmd.sum_we   = 1'b1;
      S_CNT:     cmd.cnt_inc  = 1'b1;
      S_UD_DIV:  cmd.div_start = 1'b1;
      S_UD_WAIT: cmd.cen_upd  = status.div_done;
      S_IT_END:  cmd.out_ld   = finish;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      num_points      <= kmc_pkg::NP_W'(1);
      num_dims        <= kmc_pkg::ND_W'(2);
      num_clusters    <= kmc_pkg::NK_W'(2);
      max_iter        <= kmc_pkg::ITER_W'(100);
      tolerance       <= kmc_pkg::TOL_W'(1);
      out_valid       <= 1'b0;
      iterations_done <= '0;
      converged       <= 1'b0;
      i               <= '0;
      c               <= '0;
      d               <= '0;
      iters           <= '0;
      rd_cen          <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.addr)
          kmc_pkg::REG_NUM_POINTS:   num_points   <= cfg.data[kmc_pkg::NP_W-1:0];
          kmc_pkg::REG_NUM_DIMS:     num_dims     <= cfg.data[kmc_pkg::ND_W-1:0];
          kmc_pkg::REG_NUM_CLUSTERS: num_clusters <= cfg.data[kmc_pkg::NK_W-1:0];
          kmc_pkg::REG_MAX_ITER:     max_iter     <= cfg.data[kmc_pkg::ITER_W-1:0];
          kmc_pkg::REG_TOLERANCE:    tolerance    <= cfg.data[kmc_pkg::TOL_W-1:0];
          default: begin
          end
        endcase
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (req.opcode)
              kmc_pkg::OP_RUN: begin
                if (max_iter == '0) begin
                  iterations_done <= '0;
                  converged       <= 1'b0;
                  out_valid       <= 1'b1;
                end else begin
                  iters <= '0;
                  state <= S_IT_START;
                end
              end
              kmc_pkg::OP_READ_ASG, kmc_pkg::OP_READ_CEN: begin
                rd_cen <= (req.opcode == kmc_pkg::OP_READ_CEN);
                state  <= S_RD_WAIT;
              end
              default: out_valid <= 1'b1;
            endcase
          end
        end
        S_RD_WAIT: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        S_IT_START: begin
          iters <= iters + 1'b1;
          i     <= '0;
          state <= S_PT_HEAD;
        end
        S_PT_HEAD: begin
          c <= '0;
          if (nk != '0 && i < np) begin
            state <= S_CL_HEAD;
          end else begin
            state <= S_UPD_HEAD;
          end
        end
        S_CL_HEAD: begin
          d <= '0;
          state <= (c < nk) ? S_D_HEAD : S_ASG;
        end
        S_D_HEAD:  state <= (d < nd) ? S_D_MUL : S_BEST;
        S_D_MUL:   state <= S_D_ACC;
        S_D_ACC: begin
          d     <= d + 1'b1;
          state <= S_D_HEAD;
        end
        S_BEST: begin
          c     <= c + 1'b1;
          state <= S_CL_HEAD;
        end
        S_ASG: begin
          d     <= '0;
          state <= S_AC_HEAD;
        end
        S_AC_HEAD: state <= (d < nd) ? S_AC_WR : S_CNT;
        S_AC_WR: begin
          d     <= d + 1'b1;
          state <= S_AC_HEAD;
        end
        S_CNT: begin
          i     <= i + 1'b1;
          state <= S_PT_HEAD;
        end
        S_UPD_HEAD: begin
          if (c < nk) begin
            if (status.count_zero) begin
              c <= c + 1'b1;
            end else begin
              d     <= '0;
              state <= S_UD_HEAD;
            end
          end else begin
            state <= S_IT_END;
          end
        end
        S_UD_HEAD: begin
          if (d < nd) begin
            state <= S_UD_DIV;
          end else begin
            c     <= c + 1'b1;
            state <= S_UPD_HEAD;
          end
        end
        S_UD_DIV: state <= S_UD_WAIT;
        S_UD_WAIT: begin
          if (status.div_done) begin
            d     <= d + 1'b1;
            state <= S_UD_HEAD;
          end
        end
        S_IT_END: begin
          if (finish) begin
            iterations_done <= iters;
            converged       <= !status.moved;
            out_valid       <= 1'b1;
            state           <= S_IDLE;
          end else begin
            state <= S_IT_START;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/kmeans_clustering_engine.sv -----
`timescale 1ns / 1ps
// Top level of the Lloyd k-means clustering engine.
// Load and unused-opcode items answer straight from the idle state and read items after a
// read-wait state for the registered memory read; a request is taken only while no response
// is left waiting. A run item with a nonzero iteration limit holds off the request channel
// until clustering ends; each iteration does one distance multiply per point, coordinate and
// cluster, and the bit-serial divider forms each coordinate mean of a non-empty cluster.
module kmeans_clustering_engine (
  input  logic    clk,
  input  logic    rst,
  kmc_in_if.sink  req,
  kmc_out_if.source rsp,
  kmc_cfg_if.sink cfg
);

  kmc_pkg::cmd_t    cmd;
  kmc_pkg::status_t status;
  logic             out_valid;
  logic [kmc_pkg::ITER_W-1:0] iterations_done;
  logic             converged;
  logic signed [kmc_pkg::COORD_W-1:0] read_value;

  kmc_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .req             (req),
    .cfg             (cfg),
    .out_ready       (rsp.ready),
    .out_valid       (out_valid),
    .iterations_done (iterations_done),
    .converged       (converged),
    .status          (status),
    .cmd             (cmd)
  );

  kmc_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .read_value (read_value)
  );

  assign rsp.valid           = out_valid;
  assign rsp.read_value      = read_value;
  assign rsp.iterations_done = iterations_done;
  assign rsp.converged       = converged;

endmodule

// ----- sv/kmc_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the k-means engine and its binding to the top level.
module kmc_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               req_valid,
  input logic                               req_ready,
  input logic [kmc_pkg::OP_W-1:0]           req_opcode,
  input logic                               rsp_valid,
  input logic                               rsp_ready,
  input logic signed [kmc_pkg::COORD_W-1:0] rsp_read_value,
  input logic [kmc_pkg::ITER_W-1:0]         rsp_iterations_done,
  input logic                               rsp_converged
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !req_ready)
    else $error("request taken while a response is still waiting");

  a_load_result: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready &&
    (req_opcode == kmc_pkg::OP_LOAD_PT || req_opcode == kmc_pkg::OP_LOAD_CEN)
    |=> rsp_valid && rsp_read_value == '0)
    else $error("load item did not answer with zero in the next cycle");

  a_conv_iters: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_converged |-> rsp_iterations_done != '0)
    else $error("converged reported without any iteration");

endmodule

bind kmeans_clustering_engine kmc_checker u_kmc_checker (
  .clk                 (clk),
  .rst                 (rst),
  .req_valid           (req.valid),
  .req_ready           (req.ready),
  .req_opcode          (req.opcode),
  .rsp_valid           (rsp.valid),
  .rsp_ready           (rsp.ready),
  .rsp_read_value      (rsp.read_value),
  .rsp_iterations_done (rsp.iterations_done),
  .rsp_converged       (rsp.converged)
);

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the k-means engine: directed table, clustering phases, random items.
module testbench;
  import kmc_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;
  localparam int STALL_LIMIT = 1000000;

  typedef struct packed {
    logic signed [COORD_W-1:0] read_value;
    logic [ITER_W-1:0]         iterations_done;
    logic                      converged;
  } result_t;

  typedef struct packed {
    logic    typed;
    result_t value;
  } tag_t;

  typedef struct {
    logic [OP_W-1:0]           op;
    int                        pidx;
    int                        cidx;
    int                        didx;
    logic signed [COORD_W-1:0] coord;
    logic                      typed;
    result_t                   value;
  } row_t;

  logic clk;
  logic rst;
  kmc_in_if  req ();
  kmc_out_if rsp ();
  kmc_cfg_if cfg ();

  kmeans_clustering_engine u_top (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg));

  int pts [MAX_POINTS*MAX_DIMS];
  int cens [MAX_CLUSTERS*MAX_DIMS];
  int asg [MAX_POINTS];
  bit asg_ok [MAX_POINTS];
  bit cen_ok [MAX_CLUSTERS*MAX_DIMS];
  int unsigned n_points = 1, n_dims = 2, n_clusters = 2, iter_limit = 100, tol = 1;
  int unsigned last_iters = 0;
  bit last_conv = 0;

  result_t expected_q[$];
  tag_t    tag_q[$];
  int      errors = 0;
  int      sent_items = 0;
  bit      no_gaps = 0;
  bit      long_hold = 0;
  int      quiet_cycles = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned cap(int unsigned v, int unsigned hi);
    return v > hi ? hi : v;
  endfunction

  function automatic void cluster_run();
    int unsigned np, nd, nk, it;
    bit conv, moved;
    longint sums [MAX_CLUSTERS*MAX_DIMS];
    int cnt [MAX_CLUSTERS];
    longint unsigned best_d, sq_sum;
    longint diff;
    int best, nv, delta;
    np = cap(n_points, MAX_POINTS);
    nd = cap(n_dims, MAX_DIMS);
    nk = cap(n_clusters, MAX_CLUSTERS);
    it = 0;
    conv = 0;
    while (it < iter_limit) begin
      moved = 0;
      it++;
      if (nk > 0) begin
        for (int i = 0; i < np; i++) begin
          best_d = '1;
          best = 0;
          for (int c = 0; c < nk; c++) begin
            sq_sum = 0;
            for (int d = 0; d < nd; d++) begin
              diff = longint'(pts[i*MAX_DIMS+d]) - longint'(cens[c*MAX_DIMS+d]);
              sq_sum += longint'(diff * diff);
            end
            if (sq_sum < best_d) begin
              best_d = sq_sum;
              best = c;
            end
          end
          asg[i] = best;
          asg_ok[i] = 1;
        end
      end
      for (int c = 0; c < nk; c++) begin
        cnt[c] = 0;
        for (int d = 0; d < nd; d++) sums[c*MAX_DIMS+d] = 0;
      end
      if (nk > 0) begin
        for (int i = 0; i < np; i++) begin
          cnt[asg[i]]++;
          for (int d = 0; d < nd; d++) sums[asg[i]*MAX_DIMS+d] += pts[i*MAX_DIMS+d];
        end
      end
      for (int c = 0; c < nk; c++) begin
        if (cnt[c] != 0) begin
          for (int d = 0; d < nd; d++) begin
            nv = int'(sums[c*MAX_DIMS+d] / longint'(cnt[c]));
            delta = nv - cens[c*MAX_DIMS+d];
            if (delta < 0) delta = -delta;
            if (delta > int'(tol)) moved = 1;
            cens[c*MAX_DIMS+d] = nv;
          end
        end
      end
      if (!moved) begin
        conv = 1;
        break;
      end
    end
    last_iters = it & 16'hFFFF;
    last_conv = conv;
  endfunction

  function automatic result_t engine_step(logic [OP_W-1:0] op, int pi, int ci, int di,
                                          logic signed [COORD_W-1:0] coord);
    result_t r;
    r.read_value = '0;
    case (op)
      OP_LOAD_PT: pts[pi*MAX_DIMS+di] = int'(coord);
      OP_LOAD_CEN: begin
        cens[ci*MAX_DIMS+di] = int'(coord);
        cen_ok[ci*MAX_DIMS+di] = 1;
      end
      OP_RUN: cluster_run();
      OP_READ_ASG: r.read_value = COORD_W'(asg[pi]);
      OP_READ_CEN: r.read_value = COORD_W'(cens[ci*MAX_DIMS+di]);
      default: ;
    endcase
    r.iterations_done = ITER_W'(last_iters);
    r.converged = last_conv;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t pred, got, want;
    tag_t tag;
    if (!rst) begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.addr)
          REG_NUM_POINTS:   n_points = cfg.data & 16'h7FF;
          REG_NUM_DIMS:     n_dims = cfg.data & 16'hF;
          REG_NUM_CLUSTERS: n_clusters = cfg.data & 16'h1F;
          REG_MAX_ITER:     iter_limit = cfg.data;
          REG_TOLERANCE:    tol = cfg.data;
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        pred = engine_step(req.opcode, req.point_index, req.cluster_index, req.dim_index,
                           req.coord_value);
        tag = tag_q.pop_front();
        expected_q.push_back(tag.typed ? tag.value : pred);
      end
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.read_value, rsp.iterations_done, rsp.converged};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (want.read_value !== got.read_value) begin
            $display("%0t: read_value expected %0d actual %0d", $time, want.read_value,
                     got.read_value);
            errors++;
          end
          if (want.iterations_done !== got.iterations_done) begin
            $display("%0t: iterations_done expected %0d actual %0d", $time,
                     want.iterations_done, got.iterations_done);
            errors++;
          end
          if (want.converged !== got.converged) begin
            $display("%0t: converged expected %0d actual %0d", $time, want.converged,
                     got.converged);
            errors++;
          end
        end
      end
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int n;
    rsp.ready <= 0;
    forever begin
      if (long_hold) begin
        rsp.ready <= 0;
        repeat (400) @(posedge clk);
        long_hold = 0;
      end
      n = no_gaps ? 0 : $urandom_range(0, 14);
      if (n > 0) begin
        rsp.ready <= 0;
        repeat (n) @(posedge clk);
      end
      rsp.ready <= 1;
      do @(posedge clk); while (!rsp.valid);
    end
  end

  task automatic send_item(logic [OP_W-1:0] op, int pi, int ci, int di,
                           logic signed [COORD_W-1:0] coord, logic typed = 0,
                           result_t value = '0);
    int n;
    n = no_gaps ? 0 : $urandom_range(0, 14);
    if (n > 0) begin
      req.valid <= 0;
      repeat (n) @(posedge clk);
    end
    tag_q.push_back('{typed, value});
    req.valid <= 1;
    req.opcode <= op;
    req.point_index <= PT_W'(pi);
    req.cluster_index <= CL_W'(ci);
    req.dim_index <= DIM_W'(di);
    req.coord_value <= coord;
    do @(posedge clk); while (!req.ready);
    sent_items++;
  endtask

  task automatic drain();
    req.valid <= 0;
    while (tag_q.size() != 0 || expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, int unsigned value);
    cfg.valid <= 1;
    cfg.addr <= idx;
    cfg.data <= CFG_DW'(value);
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 0;
  endtask

  task automatic configure(int unsigned np, int unsigned nd, int unsigned nk,
                           int unsigned mi, int unsigned tl);
    drain();
    write_reg(REG_NUM_POINTS, np);
    write_reg(REG_NUM_DIMS, nd);
    write_reg(REG_NUM_CLUSTERS, nk);
    write_reg(REG_MAX_ITER, mi);
    write_reg(REG_TOLERANCE, tl);
    @(posedge clk);
  endtask

  function automatic logic signed [COORD_W-1:0] rand_coord();
    return COORD_W'($urandom_range(0, 65535));
  endfunction

  task automatic random_items(int count);
    int pi, ci, di, k, pick;
    for (int j = 0; j < count; j++) begin
      pick = $urandom_range(0, 9);
      pi = $urandom_range(0, MAX_POINTS - 1);
      ci = $urandom_range(0, MAX_CLUSTERS - 1);
      di = $urandom_range(0, MAX_DIMS - 1);
      if (pick < 4) begin
        for (k = 0; k < 40 && !asg_ok[pi]; k++) pi = $urandom_range(0, MAX_POINTS - 1);
        if (asg_ok[pi]) send_item(OP_READ_ASG, pi, ci, di, rand_coord());
      end else if (pick < 7) begin
        for (k = 0; k < 40 && !cen_ok[ci*MAX_DIMS+di]; k++) begin
          ci = $urandom_range(0, MAX_CLUSTERS - 1);
          di = $urandom_range(0, MAX_DIMS - 1);
        end
        if (cen_ok[ci*MAX_DIMS+di]) send_item(OP_READ_CEN, pi, ci, di, rand_coord());
      end else if (pick < 8) begin
        send_item(OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), pi, ci, di,
                  rand_coord());
      end else begin
        send_item(pick == 8 ? OP_LOAD_PT : OP_LOAD_CEN, pi, ci, di, rand_coord());
      end
    end
  endtask

  // Loads grouped points and seed centroids for the given sizes, runs, then sends random items.
  task automatic cluster_phase(int unsigned np, int unsigned nd, int unsigned nk,
                               int unsigned mi, int unsigned tl, int reads);
    int unsigned enp, end_, enk;
    int centers [MAX_CLUSTERS*MAX_DIMS];
    int spread, v, g;
    configure(np, nd, nk, mi, tl);
    no_gaps = ($urandom_range(0, 3) == 0);
    enp = cap(np, MAX_POINTS);
    end_ = cap(nd, MAX_DIMS);
    enk = cap(nk, MAX_CLUSTERS);
    spread = $urandom_range(0, 3) == 0 ? 32767 : $urandom_range(10, 2000);
    foreach (centers[i]) centers[i] = $urandom_range(0, 40000) - 20000;
    for (int i = 0; i < enp; i++) begin
      g = $urandom_range(0, enk > 0 ? enk - 1 : 0);
      for (int d = 0; d < end_; d++) begin
        v = centers[g*MAX_DIMS+d] + $urandom_range(0, 2 * spread) - spread;
        v = v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
        send_item(OP_LOAD_PT, i, 0, d, COORD_W'(v));
      end
    end
    for (int c = 0; c < enk; c++)
      for (int d = 0; d < end_; d++) send_item(OP_LOAD_CEN, 0, c, d, rand_coord());
    send_item(OP_RUN, 0, 0, 0, rand_coord());
    random_items(reads);
  endtask

  initial begin
    row_t rows[$];
    rst <= 1;
    req.valid <= 0;
    req.opcode <= OP_LOAD_PT;
    req.point_index <= 0;
    req.cluster_index <= 0;
    req.dim_index <= 0;
    req.coord_value <= 0;
    cfg.valid <= 0;
    cfg.addr <= REG_NUM_POINTS;
    cfg.data <= 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    rows = '{
      '{OP_LOAD_PT, 0, 0, 0, 16'sh7FFF, 1, '{16'sd0, 16'd0, 1'b0}},
      '{OP_LOAD_PT, 0, 0, 1, 16'sh8000, 1, '{16'sd0, 16'd0, 1'b0}},
      '{OP_LOAD_CEN, 0, 0, 0, 16'sh8000, 1, '{16'sd0, 16'd0, 1'b0}},
      '{OP_LOAD_CEN, 0, 0, 1, 16'sh7FFF, 1, '{16'sd0, 16'd0, 1'b0}},
      '{OP_LOAD_CEN, 0, 15, 7, 16'sh1234, 1, '{16'sd0, 16'd0, 1'b0}},
      '{OP_LOAD_PT, 1023, 0, 7, -16'sd1, 1, '{16'sd0, 16'd0, 1'b0}},
      '{OP_READ_CEN, 0, 0, 0, 16'sh0, 1, '{16'sh8000, 16'd0, 1'b0}},
      '{OP_READ_CEN, 1023, 15, 7, -16'sd1, 1, '{16'sh1234, 16'd0, 1'b0}},
      '{OP_SPARE_FIRST, 1023, 15, 7, -16'sd1, 1, '{16'sd0, 16'd0, 1'b0}},
      '{OP_SPARE_LAST, 0, 0, 0, 16'sh0, 1, '{16'sd0, 16'd0, 1'b0}},
      '{OP_LOAD_CEN, 0, 1, 0, 16'sh0, 1, '{16'sd0, 16'd0, 1'b0}},
      '{OP_LOAD_CEN, 0, 1, 1, 16'sh0, 1, '{16'sd0, 16'd0, 1'b0}},
      '{OP_RUN, 0, 0, 0, 16'sh0, 0, '0},
      '{OP_READ_ASG, 0, 0, 0, 16'sh0, 0, '0},
      '{OP_READ_CEN, 0, 0, 0, 16'sh0, 0, '0},
      '{OP_READ_CEN, 0, 0, 1, 16'sh0, 0, '0},
      '{OP_READ_CEN, 0, 1, 1, 16'sh0, 0, '0}
    };
    foreach (rows[i])
      send_item(rows[i].op, rows[i].pidx, rows[i].cidx, rows[i].didx, rows[i].coord,
                rows[i].typed, rows[i].value);

    // Degenerate settings: no points, no clusters, no dims, no iterations.
    configure(0, 2, 2, 100, 1);
    send_item(OP_RUN, 0, 0, 0, 0);
    configure(1, 2, 0, 100, 1);
    send_item(OP_RUN, 0, 0, 0, 0);
    configure(1, 0, 2, 100, 1);
    send_item(OP_RUN, 0, 0, 0, 0);
    send_item(OP_READ_ASG, 0, 0, 0, 0);
    configure(1, 2, 2, 0, 1);
    send_item(OP_RUN, 0, 0, 0, 0);

    cluster_phase(3, 15, 31, 65535, 65535, 10);
    cluster_phase(6, 8, 16, 65535, 0, 10);
    cluster_phase(5, 2, 3, 1, 0, 10);

    // Full point store, with the receiver held off while the loads stream in.
    configure(2047, 1, 1, 2, 65535);
    no_gaps = 1;
    long_hold = 1;
    for (int i = 0; i < MAX_POINTS; i++)
      send_item(OP_LOAD_PT, i, 0, 0, $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000);
    send_item(OP_LOAD_CEN, 0, 0, 0, rand_coord());
    send_item(OP_RUN, 0, 0, 0, 0);
    random_items(40);

    while (sent_items < 1600)
      cluster_phase($urandom_range(1, 40), $urandom_range(1, 4), $urandom_range(1, 6),
                    $urandom_range(1, 12), $urandom_range(0, 300), $urandom_range(10, 40));

    drain();
    repeat (40) @(posedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
